/* sv/ieu_pkg.sv */
// Shared types, codes and helper functions for the input event classifier.
// No dependencies; every module of the classifier imports this package.
package ieu_pkg;

    // Width of the stored last-move timestamp.
    localparam int TIME_BITS = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RECORD_MASK  = 2'd0;
    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_MIN_DISTANCE = 2'd2;
    localparam logic [1:0] CFG_START_TIME   = 2'd3;

    // Record mask bit positions.
    localparam int MASK_MOVE  = 0;
    localparam int MASK_CLICK = 1;
    localparam int MASK_WHEEL = 2;
    localparam int MASK_KEY   = 3;

    // Event kinds.
    localparam logic [2:0] KIND_MOVE     = 3'd0;
    localparam logic [2:0] KIND_DOWN     = 3'd1;
    localparam logic [2:0] KIND_UP       = 3'd2;
    localparam logic [2:0] KIND_WHEEL    = 3'd3;
    localparam logic [2:0] KIND_HWHEEL   = 3'd4;
    localparam logic [2:0] KIND_KEY_DOWN = 3'd5;
    localparam logic [2:0] KIND_KEY_UP   = 3'd6;

    // Button codes.
    localparam logic [2:0] BTN_NONE   = 3'd0;
    localparam logic [2:0] BTN_LEFT   = 3'd1;
    localparam logic [2:0] BTN_RIGHT  = 3'd2;
    localparam logic [2:0] BTN_MIDDLE = 3'd3;
    localparam logic [2:0] BTN_X1     = 3'd4;
    localparam logic [2:0] BTN_X2     = 3'd5;

    // Mouse message codes.
    localparam logic [15:0] MSG_MOVE     = 16'h0200;
    localparam logic [15:0] MSG_LDOWN    = 16'h0201;
    localparam logic [15:0] MSG_LUP      = 16'h0202;
    localparam logic [15:0] MSG_RDOWN    = 16'h0204;
    localparam logic [15:0] MSG_RUP      = 16'h0205;
    localparam logic [15:0] MSG_MDOWN    = 16'h0207;
    localparam logic [15:0] MSG_MUP      = 16'h0208;
    localparam logic [15:0] MSG_WHEEL    = 16'h020A;
    localparam logic [15:0] MSG_XDOWN    = 16'h020B;
    localparam logic [15:0] MSG_XUP      = 16'h020C;
    localparam logic [15:0] MSG_HWHEEL   = 16'h020E;

    // X button number that selects the first extra button.
    localparam logic [15:0] XBUTTON_ONE = 16'h0001;

    // Event source selector.
    localparam logic SRC_MOUSE = 1'b0;
    localparam logic SRC_KEY   = 1'b1;

    // Key flag bit positions.
    localparam int KEY_FLAG_UP  = 7;
    localparam int KEY_FLAG_EXT = 0;

    // Modifier bits.
    localparam logic [3:0] MOD_CTRL  = 4'h1;
    localparam logic [3:0] MOD_SHIFT = 4'h2;
    localparam logic [3:0] MOD_ALT   = 4'h4;
    localparam logic [3:0] MOD_WIN   = 4'h8;
    localparam logic [3:0] MOD_NONE  = 4'h0;

    // Virtual key codes of the modifier keys.
    localparam logic [7:0] KEY_SHIFT  = 8'h10;
    localparam logic [7:0] VK_CTRL    = 8'h11;
    localparam logic [7:0] VK_ALT     = 8'h12;
    localparam logic [7:0] VK_LWIN    = 8'h5B;
    localparam logic [7:0] VK_RWIN    = 8'h5C;
    localparam logic [7:0] KEY_LSHIFT = 8'hA0;
    localparam logic [7:0] KEY_RSHIFT = 8'hA1;
    localparam logic [7:0] VK_LCTRL   = 8'hA2;
    localparam logic [7:0] VK_RCTRL   = 8'hA3;
    localparam logic [7:0] VK_LALT    = 8'hA4;
    localparam logic [7:0] VK_RALT    = 8'hA5;

    // One raw input event.
    typedef struct packed {
        logic               op;
        logic        [31:0] time_ms;
        logic        [15:0] mouse_message;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic        [31:0] mouse_data;
        logic        [7:0]  vk_code;
        logic        [15:0] scan_code;
        logic        [7:0]  key_flags;
    } t_item;

    // One classified event.
    typedef struct packed {
        logic        [2:0]  event_kind;
        logic        [2:0]  button;
        logic        [31:0] rel_time_ms;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] wheel_delta;
        logic        [7:0]  key_code;
        logic        [15:0] key_scan;
        logic               extended;
        logic        [3:0]  modifiers;
    } t_result;

    // Configuration register contents.
    typedef struct packed {
        logic [3:0]  record_mask;
        logic [15:0] min_interval_ms;
        logic [16:0] min_distance;
        logic [31:0] start_time_ms;
    } t_cfg;

    // Modifier bit touched by a virtual key, none for ordinary keys.
    function automatic logic [3:0] modifier_bit(input logic [7:0] vk);
        logic [3:0] bit_sel;
        case (vk) inside
            VK_CTRL, VK_LCTRL, VK_RCTRL:       bit_sel = MOD_CTRL;
            KEY_SHIFT, KEY_LSHIFT, KEY_RSHIFT: bit_sel = MOD_SHIFT;
            VK_ALT, VK_LALT, VK_RALT:          bit_sel = MOD_ALT;
            VK_LWIN, VK_RWIN:                  bit_sel = MOD_WIN;
            default:                           bit_sel = MOD_NONE;
        endcase
        return bit_sel;
    endfunction

endpackage

/* sv/ieu_in_reg.sv */
// Input register stage of the input event classifier.
// Depends on ieu_pkg for the event type.
module ieu_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ieu_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output ieu_pkg::t_item o_item
);
    import ieu_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The stage takes a new transaction when empty or when its content moves on.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Event payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* sv/ieu_classify.sv */
// Classification stage: decodes one event, applies the mask and move filter,
// keeps modifier and last-move state, and holds the result register.
// Depends on ieu_pkg for types, codes and the modifier lookup.
module ieu_classify (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ieu_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  ieu_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output ieu_pkg::t_result o_result
);
    import ieu_pkg::*;

    logic                 r_out_valid;
    t_result              r_result;
    logic [3:0]           r_mods;
    logic                 r_last_valid;
    logic [TIME_BITS-1:0] r_last_time;
    logic signed [15:0]   r_last_x;
    logic signed [15:0]   r_last_y;

    logic                 advance;
    logic                 fire;
    logic                 keep;
    logic                 is_move;
    logic                 known;
    logic [3:0]           need;
    logic [31:0]          rel;
    logic [15:0]          hi;
    logic [2:0]           xbtn;
    logic [3:0]           mod_sel;
    logic                 key_up;
    logic [3:0]           n_mods;
    logic [TIME_BITS-1:0] rel_t;
    logic [TIME_BITS-1:0] dt;
    logic signed [16:0]   dx;
    logic signed [16:0]   dy;
    logic [15:0]          adx;
    logic [15:0]          ady;
    logic [16:0]          manhattan;
    logic                 too_close;
    t_result              n_result;

    // The result register frees when empty or when its transaction is taken.
    assign advance = !r_out_valid || i_ready;
    assign o_ready = advance;
    assign fire    = i_valid && advance;

    // Common terms.
    assign rel     = i_item.time_ms - i_cfg.start_time_ms;
    assign hi      = i_item.mouse_data[31:16];
    assign xbtn    = (hi == XBUTTON_ONE) ? BTN_X1 : BTN_X2;
    assign mod_sel = modifier_bit(i_item.vk_code);
    assign key_up  = i_item.key_flags[KEY_FLAG_UP];
    assign n_mods  = key_up ? (r_mods & ~mod_sel) : (r_mods | mod_sel);

    // Move filter: wrapped time since the last kept move and Manhattan distance.
    assign rel_t     = TIME_BITS'(rel);
    assign dt        = rel_t - r_last_time;
    assign dx        = 17'(i_item.pos_x) - 17'(r_last_x);
    assign dy        = 17'(i_item.pos_y) - 17'(r_last_y);
    assign adx       = dx[16] ? 16'(-dx) : dx[15:0];
    assign ady       = dy[16] ? 16'(-dy) : dy[15:0];
    assign manhattan = 17'(adx) + 17'(ady);
    assign too_close = r_last_valid
                    && (dt < TIME_BITS'(i_cfg.min_interval_ms))
                    && (manhattan < i_cfg.min_distance);

    // Message decode and result assembly.
    always_comb begin
        n_result             = '0;
        n_result.rel_time_ms = rel;
        known                = 1'b0;
        need                 = '0;
        is_move              = 1'b0;
        if (i_item.op == SRC_KEY) begin
            known               = 1'b1;
            need[MASK_KEY]      = 1'b1;
            n_result.event_kind = key_up ? KIND_KEY_UP : KIND_KEY_DOWN;
            n_result.key_code   = i_item.vk_code;
            n_result.key_scan   = i_item.scan_code;
            n_result.extended   = i_item.key_flags[KEY_FLAG_EXT];
            n_result.modifiers  = n_mods;
        end else begin
            n_result.out_x = i_item.pos_x;
            n_result.out_y = i_item.pos_y;
            known          = 1'b1;
            unique case (i_item.mouse_message)
                MSG_MOVE: begin
                    n_result.event_kind = KIND_MOVE;
                    need[MASK_MOVE]     = 1'b1;
                    is_move             = 1'b1;
                end
                MSG_LDOWN: begin
                    n_result.event_kind = KIND_DOWN;
                    n_result.button     = BTN_LEFT;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_LUP: begin
                    n_result.event_kind = KIND_UP;
                    n_result.button     = BTN_LEFT;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_RDOWN: begin
                    n_result.event_kind = KIND_DOWN;
                    n_result.button     = BTN_RIGHT;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_RUP: begin
                    n_result.event_kind = KIND_UP;
                    n_result.button     = BTN_RIGHT;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_MDOWN: begin
                    n_result.event_kind = KIND_DOWN;
                    n_result.button     = BTN_MIDDLE;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_MUP: begin
                    n_result.event_kind = KIND_UP;
                    n_result.button     = BTN_MIDDLE;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_XDOWN: begin
                    n_result.event_kind = KIND_DOWN;
                    n_result.button     = xbtn;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_XUP: begin
                    n_result.event_kind = KIND_UP;
                    n_result.button     = xbtn;
                    need[MASK_CLICK]    = 1'b1;
                end
                MSG_WHEEL: begin
                    n_result.event_kind  = KIND_WHEEL;
                    n_result.wheel_delta = hi;
                    need[MASK_WHEEL]     = 1'b1;
                end
                MSG_HWHEEL: begin
                    n_result.event_kind  = KIND_HWHEEL;
                    n_result.wheel_delta = hi;
                    need[MASK_WHEEL]     = 1'b1;
                end
                default: begin
                    known = 1'b0;
                end
            endcase
        end
        keep = known && ((need & i_cfg.record_mask) != '0) && !(is_move && too_close);
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && keep) begin
            r_result <= n_result;
        end
    end

    // Modifier state follows every recorded key event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods <= '0;
        end else if (fire && keep && i_item.op == SRC_KEY) begin
            r_mods <= n_mods;
        end
    end

    // Last kept move.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
            r_last_time  <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
        end else if (fire && keep && is_move) begin
            r_last_valid <= 1'b1;
            r_last_time  <= rel_t;
            r_last_x     <= i_item.pos_x;
            r_last_y     <= i_item.pos_y;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

/* sv/input_event_classifier_unit.sv */
// Top level of the input event classifier: stream ports, configuration
// registers and the two pipeline stages. Depends on ieu_pkg, ieu_in_reg
// and ieu_classify.
//
// The unit takes one raw mouse or keyboard event per transaction and emits
// at most one classified event. It accepts a new event every clock cycle
// while the output is not stalled; each event passes the input register,
// then decode, mask, move filter and state update into the result register.
// Modifier and last-move state are updated in the decode cycle, so back-to-back
// events see each other's effect. Dropped events (unknown message, masked
// class, filtered move) produce no output transaction. Configuration writes
// take effect at once and are meant for idle periods.
module input_event_classifier_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration write port.
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    // Event input stream.
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: time_ms[31:0], mouse_message[47:32], pos_x[63:48], pos_y[79:64],
    //        mouse_data[111:80], vk_code[119:112], scan_code[135:120],
    //        key_flags[143:136]
    input  logic [143:0]  s_tdata,
    // tuser: op[0]
    input  logic          s_tuser,
    // Classified event output stream.
    output logic          m_tvalid,
    input  logic          m_tready,
    // tdata: button[2:0], rel_time_ms[34:3], out_x[50:35], out_y[66:51],
    //        wheel_delta[82:67], key_code[90:83], key_scan[106:91],
    //        extended[107], modifiers[111:108]
    output logic [111:0]  m_tdata,
    // tuser: event_kind[2:0]
    output logic [2:0]    m_tuser
);
    import ieu_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   stage_item;
    t_result result;
    logic    stage_valid;
    logic    stage_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_mask     <= 4'hF;
            r_cfg.min_interval_ms <= '0;
            r_cfg.min_distance    <= '0;
            r_cfg.start_time_ms   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RECORD_MASK:  r_cfg.record_mask     <= i_cfg_data[3:0];
                CFG_MIN_INTERVAL: r_cfg.min_interval_ms <= i_cfg_data[15:0];
                CFG_MIN_DISTANCE: r_cfg.min_distance    <= i_cfg_data[16:0];
                CFG_START_TIME:   r_cfg.start_time_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input transaction.
    always_comb begin
        in_item.op            = s_tuser;
        in_item.time_ms       = s_tdata[31:0];
        in_item.mouse_message = s_tdata[47:32];
        in_item.pos_x         = s_tdata[63:48];
        in_item.pos_y         = s_tdata[79:64];
        in_item.mouse_data    = s_tdata[111:80];
        in_item.vk_code       = s_tdata[119:112];
        in_item.scan_code     = s_tdata[135:120];
        in_item.key_flags     = s_tdata[143:136];
    end

    ieu_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_ready (stage_ready),
        .o_item  (stage_item)
    );

    ieu_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (stage_valid),
        .o_ready  (stage_ready),
        .i_item   (stage_item),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (result)
    );

    // Pack the output transaction.
    assign m_tuser = result.event_kind;
    assign m_tdata = {result.modifiers, result.extended, result.key_scan, result.key_code,
                      result.wheel_delta, result.out_y, result.out_x, result.rel_time_ms,
                      result.button};

endmodule

/* bench/ieu_event_checker.sv */
// Scoreboard for the input event classifier: watches the configuration port
// and both stream channels, predicts each classified event and compares it.
// Depends on ieu_pkg for the event, result and configuration types and codes.
module ieu_event_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic          s_tvalid,
    input  logic          s_tready,
    // tdata: time_ms, mouse_message, pos_x, pos_y, mouse_data, vk_code,
    //        scan_code, key_flags
    input  logic [143:0]  s_tdata,
    // tuser: op
    input  logic          s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    // tdata: button, rel_time_ms, out_x, out_y, wheel_delta, key_code,
    //        key_scan, extended, modifiers
    input  logic [111:0]  m_tdata,
    // tuser: event_kind
    input  logic [2:0]    m_tuser,
    output int            o_fail_count,
    output int            o_pending
);
    import ieu_pkg::*;

    // Shadow copy of the configuration registers and of the block state.
    t_cfg               shadow_cfg;
    logic [3:0]         held_mods;
    logic               move_seen;
    logic [31:0]        move_time;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;

    // Classified events still to come out of the block, oldest first.
    t_result            expected_events[$];
    int                 fail_count = 0;

    t_item              in_event;
    t_result            predicted;
    t_result            observed;
    t_result            oldest;
    logic               kept;

    assign o_fail_count = fail_count;

    // One line per mismatch, and one more failure on the count.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Modifier bit that a virtual key code holds, or none.
    function automatic logic [3:0] key_modifier(input logic [7:0] vk);
        logic [3:0] sel;
        sel = MOD_NONE;
        if (vk == VK_CTRL || vk == VK_LCTRL || vk == VK_RCTRL) sel = MOD_CTRL;
        if (vk == KEY_SHIFT || vk == KEY_LSHIFT || vk == KEY_RSHIFT) sel = MOD_SHIFT;
        if (vk == VK_ALT || vk == VK_LALT || vk == VK_RALT) sel = MOD_ALT;
        if (vk == VK_LWIN || vk == VK_RWIN) sel = MOD_WIN;
        return sel;
    endfunction

    // Classify one raw event against the shadow state; updates that state.
    task automatic classify_event(input t_item ev, output logic keep, output t_result res);
        logic [31:0] rel;
        logic [15:0] hi;
        logic [3:0]  mbit;
        logic [31:0] dt;
        int          class_bit;
        int          dx;
        int          dy;
        int          manhattan;
        rel  = ev.time_ms - shadow_cfg.start_time_ms;
        hi   = ev.mouse_data[31:16];
        res  = '0;
        keep = 1'b0;
        res.rel_time_ms = rel;
        if (ev.op == SRC_KEY) begin
            // A disabled keyboard class leaves the modifiers alone.
            if (!shadow_cfg.record_mask[MASK_KEY]) return;
            mbit = key_modifier(ev.vk_code);
            if (ev.key_flags[KEY_FLAG_UP]) begin
                held_mods = held_mods & ~mbit;
                res.event_kind = KIND_KEY_UP;
            end else begin
                held_mods = held_mods | mbit;
                res.event_kind = KIND_KEY_DOWN;
            end
            res.key_code  = ev.vk_code;
            res.key_scan  = ev.scan_code;
            res.extended  = ev.key_flags[KEY_FLAG_EXT];
            res.modifiers = held_mods;
            keep = 1'b1;
            return;
        end
        res.out_x = ev.pos_x;
        res.out_y = ev.pos_y;
        class_bit = MASK_CLICK;
        case (ev.mouse_message)
            MSG_MOVE: begin
                res.event_kind = KIND_MOVE;
                class_bit = MASK_MOVE;
            end
            MSG_LDOWN:  begin res.event_kind = KIND_DOWN; res.button = BTN_LEFT;   end
            MSG_LUP:    begin res.event_kind = KIND_UP;   res.button = BTN_LEFT;   end
            MSG_RDOWN:  begin res.event_kind = KIND_DOWN; res.button = BTN_RIGHT;  end
            MSG_RUP:    begin res.event_kind = KIND_UP;   res.button = BTN_RIGHT;  end
            MSG_MDOWN:  begin res.event_kind = KIND_DOWN; res.button = BTN_MIDDLE; end
            MSG_MUP:    begin res.event_kind = KIND_UP;   res.button = BTN_MIDDLE; end
            MSG_XDOWN: begin
                res.event_kind = KIND_DOWN;
                res.button = (hi == XBUTTON_ONE) ? BTN_X1 : BTN_X2;
            end
            MSG_XUP: begin
                res.event_kind = KIND_UP;
                res.button = (hi == XBUTTON_ONE) ? BTN_X1 : BTN_X2;
            end
            MSG_WHEEL: begin
                res.event_kind = KIND_WHEEL;
                res.wheel_delta = hi;
                class_bit = MASK_WHEEL;
            end
            MSG_HWHEEL: begin
                res.event_kind = KIND_HWHEEL;
                res.wheel_delta = hi;
                class_bit = MASK_WHEEL;
            end
            default: return;
        endcase
        if (!shadow_cfg.record_mask[class_bit]) return;
        if (res.event_kind == KIND_MOVE) begin
            // Drop a move that is both too soon and too close to the last kept one.
            if (move_seen) begin
                dt        = rel - move_time;
                dx        = int'($signed(ev.pos_x)) - int'($signed(move_x));
                dy        = int'($signed(ev.pos_y)) - int'($signed(move_y));
                manhattan = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
                if (dt < {16'h0000, shadow_cfg.min_interval_ms} &&
                    manhattan < int'(shadow_cfg.min_distance)) return;
            end
            move_seen = 1'b1;
            move_time = rel;
            move_x    = ev.pos_x;
            move_y    = ev.pos_y;
        end
        keep = 1'b1;
    endtask

    // Field-by-field comparison of one output transaction.
    task automatic compare_event(input t_result got, input t_result want);
        if (got.event_kind != want.event_kind)
            report_mismatch("event_kind", 32'(got.event_kind), 32'(want.event_kind));
        if (got.button != want.button)
            report_mismatch("button", 32'(got.button), 32'(want.button));
        if (got.rel_time_ms != want.rel_time_ms)
            report_mismatch("rel_time_ms", got.rel_time_ms, want.rel_time_ms);
        if (got.out_x != want.out_x)
            report_mismatch("out_x", 32'(got.out_x), 32'(want.out_x));
        if (got.out_y != want.out_y)
            report_mismatch("out_y", 32'(got.out_y), 32'(want.out_y));
        if (got.wheel_delta != want.wheel_delta)
            report_mismatch("wheel_delta", 32'(got.wheel_delta), 32'(want.wheel_delta));
        if (got.key_code != want.key_code)
            report_mismatch("key_code", 32'(got.key_code), 32'(want.key_code));
        if (got.key_scan != want.key_scan)
            report_mismatch("key_scan", 32'(got.key_scan), 32'(want.key_scan));
        if (got.extended != want.extended)
            report_mismatch("extended", 32'(got.extended), 32'(want.extended));
        if (got.modifiers != want.modifiers)
            report_mismatch("modifiers", 32'(got.modifiers), 32'(want.modifiers));
    endtask

    // Track configuration writes, retire results, then predict new events.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_cfg.record_mask     = 4'hF;
            shadow_cfg.min_interval_ms = '0;
            shadow_cfg.min_distance    = '0;
            shadow_cfg.start_time_ms   = '0;
            held_mods = MOD_NONE;
            move_seen = 1'b0;
            move_time = '0;
            move_x    = '0;
            move_y    = '0;
            expected_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RECORD_MASK:  shadow_cfg.record_mask     = i_cfg_data[3:0];
                    CFG_MIN_INTERVAL: shadow_cfg.min_interval_ms = i_cfg_data[15:0];
                    CFG_MIN_DISTANCE: shadow_cfg.min_distance    = i_cfg_data[16:0];
                    CFG_START_TIME:   shadow_cfg.start_time_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                observed.event_kind  = m_tuser;
                observed.button      = m_tdata[2:0];
                observed.rel_time_ms = m_tdata[34:3];
                observed.out_x       = m_tdata[50:35];
                observed.out_y       = m_tdata[66:51];
                observed.wheel_delta = m_tdata[82:67];
                observed.key_code    = m_tdata[90:83];
                observed.key_scan    = m_tdata[106:91];
                observed.extended    = m_tdata[107];
                observed.modifiers   = m_tdata[111:108];
                if (expected_events.size() == 0) begin
                    report_mismatch("result with none expected", m_tdata[34:3], '0);
                end else begin
                    oldest = expected_events.pop_front();
                    compare_event(observed, oldest);
                end
            end
            if (s_tvalid && s_tready) begin
                in_event.op            = s_tuser;
                in_event.time_ms       = s_tdata[31:0];
                in_event.mouse_message = s_tdata[47:32];
                in_event.pos_x         = s_tdata[63:48];
                in_event.pos_y         = s_tdata[79:64];
                in_event.mouse_data    = s_tdata[111:80];
                in_event.vk_code       = s_tdata[119:112];
                in_event.scan_code     = s_tdata[135:120];
                in_event.key_flags     = s_tdata[143:136];
                classify_event(in_event, kept, predicted);
                if (kept) expected_events.push_back(predicted);
            end
        end
        o_pending = expected_events.size();
    end

endmodule

/* bench/tb_input_event_classifier_unit.sv */
// Testbench top for the input event classifier: clock, reset, stimulus,
// random back-pressure and the final verdict. Depends on ieu_pkg, the
// input_event_classifier_unit RTL and the ieu_event_checker scoreboard.
module tb_input_event_classifier_unit;
    import ieu_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 300;

    // Message codes the block does not know.
    localparam logic [15:0] MSG_GAP      = 16'h0203;
    localparam logic [15:0] MSG_ALL_ONES = 16'hFFFF;
    localparam logic [15:0] MSG_ZERO     = 16'h0000;

    // Ordinary keys and key flag patterns.
    localparam logic [7:0] VK_LETTER_A = 8'h41;
    localparam logic [7:0] FLAGS_DOWN  = 8'h00;
    localparam logic [7:0] FLAGS_UP    = 8'h80;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [31:0]   i_cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [143:0]  s_tdata;
    logic          s_tuser;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [111:0]  m_tdata;
    logic [2:0]    m_tuser;

    int            fail_count;
    int            pending;
    logic          calm = 1'b0;
    int            sink_hold = 0;
    int            idle_cycles;

    // Running stimulus state: current time and pointer position.
    logic [31:0]        now_ms;
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;

    always #5 i_clk = ~i_clk;

    input_event_classifier_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    ieu_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Length of a pause: mostly short, now and then long.
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Cycles the sender waits before the next transaction.
    function automatic int sender_gap();
        if (calm || $urandom_range(0, 99) < 55) return 0;
        return pause_length();
    endfunction

    function automatic logic [15:0] other_message(input int k);
        case (k)
            0: return MSG_LDOWN;
            1: return MSG_LUP;
            2: return MSG_RDOWN;
            3: return MSG_RUP;
            4: return MSG_MDOWN;
            5: return MSG_MUP;
            6: return MSG_XDOWN;
            7: return MSG_XUP;
            8: return MSG_WHEEL;
            default: return MSG_HWHEEL;
        endcase
    endfunction

    function automatic logic [7:0] modifier_key(input int k);
        case (k)
            0: return KEY_SHIFT;
            1: return VK_CTRL;
            2: return VK_ALT;
            3: return VK_LWIN;
            4: return VK_RWIN;
            5: return KEY_LSHIFT;
            6: return KEY_RSHIFT;
            7: return VK_LCTRL;
            8: return VK_RCTRL;
            9: return VK_LALT;
            default: return VK_RALT;
        endcase
    endfunction

    function automatic t_item mouse_ev(input logic [15:0] msg, input logic [31:0] t,
                                       input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input logic [31:0] data);
        t_item ev;
        ev = '0;
        ev.op            = SRC_MOUSE;
        ev.time_ms       = t;
        ev.mouse_message = msg;
        ev.pos_x         = x;
        ev.pos_y         = y;
        ev.mouse_data    = data;
        return ev;
    endfunction

    function automatic t_item key_ev(input logic [31:0] t, input logic [7:0] vk,
                                     input logic [15:0] scan, input logic [7:0] flags);
        t_item ev;
        ev = '0;
        ev.op        = SRC_KEY;
        ev.time_ms   = t;
        ev.vk_code   = vk;
        ev.scan_code = scan;
        ev.key_flags = flags;
        return ev;
    endfunction

    // Send one event and wait until its transaction completes.
    task automatic push_event(input t_item ev);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ev.key_flags, ev.scan_code, ev.vk_code, ev.mouse_data,
                     ev.pos_y, ev.pos_x, ev.mouse_message, ev.time_ms};
        s_tuser  <= ev.op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and let every expected event and any dropped one drain.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
    endtask

    // Write all four registers back to back; the block must be idle.
    task automatic set_config(input logic [3:0] mask, input logic [15:0] interval,
                              input logic [16:0] distance, input logic [31:0] start);
        write_reg(CFG_RECORD_MASK, 32'(mask));
        write_reg(CFG_MIN_INTERVAL, 32'(interval));
        write_reg(CFG_MIN_DISTANCE, 32'(distance));
        write_reg(CFG_START_TIME, start);
        i_cfg_we <= 1'b0;
    endtask

    // Random event: many moves, with time and position that mostly drift, some noise.
    task automatic gen_event(output t_item ev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) now_ms = now_ms + 32'($urandom_range(0, 40));
        else if (r < 85) now_ms = now_ms + 32'($urandom_range(0, 2000));
        else if (r < 92) now_ms = now_ms - 32'($urandom_range(1, 100));
        else now_ms = $urandom;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            cur_x = cur_x + 16'($urandom_range(0, 80)) - 16'd40;
            cur_y = cur_y + 16'($urandom_range(0, 80)) - 16'd40;
        end else if (r < 90) begin
            cur_x = 16'($urandom);
            cur_y = 16'($urandom);
        end else begin
            cur_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            cur_y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        ev.op      = ($urandom_range(0, 99) < 25) ? SRC_KEY : SRC_MOUSE;
        ev.time_ms = now_ms;
        ev.pos_x   = cur_x;
        ev.pos_y   = cur_y;
        r = $urandom_range(0, 99);
        if (r < 65) ev.mouse_message = MSG_MOVE;
        else if (r < 90) ev.mouse_message = other_message($urandom_range(0, 9));
        else ev.mouse_message = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30) ev.mouse_data = {XBUTTON_ONE, 16'($urandom)};
        else if (r < 40) ev.mouse_data = {($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF),
                                          16'($urandom)};
        else ev.mouse_data = $urandom;
        if ($urandom_range(0, 99) < 60) ev.vk_code = modifier_key($urandom_range(0, 10));
        else ev.vk_code = 8'($urandom);
        ev.scan_code = 16'($urandom);
        ev.key_flags = 8'($urandom);
    endtask

    // Output back-pressure: random stalls unless a calm stretch is running.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30) sink_hold <= pause_length();
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Main stimulus sequence and verdict.
    initial begin
        t_item ev;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        now_ms     = 32'd5000;
        cur_x      = '0;
        cur_y      = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: pointer extremes, every button and wheel message.
        push_event(mouse_ev(MSG_MOVE, 32'h0000_0000, 16'sh8000, 16'sh7FFF, 32'h0));
        push_event(mouse_ev(MSG_MOVE, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF));
        push_event(mouse_ev(MSG_LDOWN, 32'd10, 16'sd1, 16'sd2, 32'h0));
        push_event(mouse_ev(MSG_LUP, 32'd11, 16'sd1, 16'sd2, 32'h0));
        push_event(mouse_ev(MSG_RDOWN, 32'd12, -16'sd3, 16'sd4, 32'h0));
        push_event(mouse_ev(MSG_RUP, 32'd13, -16'sd3, 16'sd4, 32'h0));
        push_event(mouse_ev(MSG_MDOWN, 32'd14, 16'sd5, -16'sd6, 32'h0));
        push_event(mouse_ev(MSG_MUP, 32'd15, 16'sd5, -16'sd6, 32'h0));
        push_event(mouse_ev(MSG_XDOWN, 32'd16, 16'sd7, 16'sd8, {XBUTTON_ONE, 16'h0000}));
        push_event(mouse_ev(MSG_XUP, 32'd17, 16'sd7, 16'sd8, 32'h0002_FFFF));
        push_event(mouse_ev(MSG_XDOWN, 32'd18, 16'sd7, 16'sd8, 32'hFFFF_0001));
        push_event(mouse_ev(MSG_WHEEL, 32'd19, 16'sd9, 16'sd9, 32'h8000_0000));
        push_event(mouse_ev(MSG_HWHEEL, 32'd20, 16'sd9, 16'sd9, 32'h7FFF_FFFF));
        // Unknown messages give nothing.
        push_event(mouse_ev(MSG_GAP, 32'd21, 16'sd0, 16'sd0, 32'h0));
        push_event(mouse_ev(MSG_ALL_ONES, 32'd22, 16'sd0, 16'sd0, 32'h0));
        push_event(mouse_ev(MSG_ZERO, 32'd23, 16'sd0, 16'sd0, 32'h0));
        // Modifier keys down and up, an ordinary key with stray flag bits.
        push_event(key_ev(32'd30, VK_LCTRL, 16'h001D, FLAGS_DOWN));
        push_event(key_ev(32'd31, KEY_SHIFT, 16'h002A, 8'h01));
        push_event(key_ev(32'd32, VK_RALT, 16'hE038, FLAGS_DOWN));
        push_event(key_ev(32'd33, VK_LWIN, 16'hE05B, FLAGS_DOWN));
        push_event(key_ev(32'd34, VK_LETTER_A, 16'hFFFF, 8'h7F));
        push_event(key_ev(32'd35, VK_CTRL, 16'h001D, FLAGS_UP));
        push_event(key_ev(32'd36, VK_RWIN, 16'h0000, 8'hFF));
        wait_drain();

        // Every class disabled: nothing comes out and the modifiers hold.
        set_config(4'h0, 16'd100, 17'd50, 32'h0000_1000);
        push_event(key_ev(32'h1100, VK_CTRL, 16'h001D, FLAGS_DOWN));
        push_event(mouse_ev(MSG_MOVE, 32'h1100, 16'sd0, 16'sd0, 32'h0));
        push_event(mouse_ev(MSG_LDOWN, 32'h1101, 16'sd0, 16'sd0, 32'h0));
        push_event(mouse_ev(MSG_WHEEL, 32'h1102, 16'sd0, 16'sd0, 32'h0078_0000));
        wait_drain();

        // Move filter at its edges, and a timestamp before the start time.
        set_config(4'hF, 16'd100, 17'd50, 32'h0000_1000);
        push_event(key_ev(32'h1200, VK_LETTER_A, 16'h001E, FLAGS_DOWN));
        push_event(mouse_ev(MSG_MOVE, 32'h1400, 16'sd0, 16'sd0, 32'h0));
        push_event(mouse_ev(MSG_MOVE, 32'h140A, 16'sd10, 16'sd10, 32'h0));
        push_event(mouse_ev(MSG_MOVE, 32'h1414, 16'sd25, 16'sd25, 32'h0));
        push_event(mouse_ev(MSG_MOVE, 32'h140F, 16'sd25, 16'sd25, 32'h0));
        push_event(mouse_ev(MSG_WHEEL, 32'h0000_0800, 16'sd1, 16'sd1, 32'hFFFF_0000));
        wait_drain();

        // Random phases, each with its own configuration.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(4'hF, 16'd50, 17'd30, $urandom);
                1: set_config(4'($urandom), 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF);
                2: set_config(4'hF, 16'd0, 17'd0, 32'h0);
                3: set_config(4'($urandom), 16'($urandom_range(0, 200)),
                              17'($urandom_range(0, 200)), $urandom);
                4: set_config(4'h5, 16'($urandom_range(0, 60)),
                              17'($urandom_range(0, 60)), $urandom);
                default: set_config(4'($urandom), 16'hFFFF, 17'd0, $urandom);
            endcase
            calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == PHASE_ITEMS / 2) wait_drain();
                gen_event(ev);
                push_event(ev);
            end
            wait_drain();
        end
        calm = 1'b0;

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/ieu_pkg.sv
sv/ieu_in_reg.sv
sv/ieu_classify.sv
sv/input_event_classifier_unit.sv
bench/ieu_event_checker.sv
bench/tb_input_event_classifier_unit.sv
